>>> hw/rtl/stsu_pkg.sv
// Shared types, token codes and keyword table for the source token scanner.
package stsu_pkg;

   // Kinds of run that the scanner can be gathering.
   localparam logic [2:0] CLS_NONE   = 3'd0;
   localparam logic [2:0] CLS_IDENT  = 3'd1;
   localparam logic [2:0] CLS_NUMBER = 3'd2;
   localparam logic [2:0] CLS_BANG   = 3'd3;
   localparam logic [2:0] CLS_ASSIGN = 3'd4;

   // Token kind codes.
   localparam logic [4:0] TOK_ILLEGAL   = 5'd0;
   localparam logic [4:0] TOK_EOF       = 5'd1;
   localparam logic [4:0] TOK_IDENT     = 5'd2;
   localparam logic [4:0] TOK_INT       = 5'd3;
   localparam logic [4:0] TOK_ASSIGN    = 5'd4;
   localparam logic [4:0] TOK_PLUS      = 5'd5;
   localparam logic [4:0] TOK_MINUS     = 5'd6;
   localparam logic [4:0] TOK_BANG      = 5'd7;
   localparam logic [4:0] TOK_ASTERISK  = 5'd8;
   localparam logic [4:0] TOK_SLASH     = 5'd9;
   localparam logic [4:0] TOK_LT        = 5'd10;
   localparam logic [4:0] TOK_GT        = 5'd11;
   localparam logic [4:0] TOK_EQ        = 5'd12;
   localparam logic [4:0] TOK_NOT_EQ    = 5'd13;
   localparam logic [4:0] TOK_COMMA     = 5'd14;
   localparam logic [4:0] TOK_SEMICOLON = 5'd15;
   localparam logic [4:0] TOK_LPAREN    = 5'd16;
   localparam logic [4:0] TOK_RPAREN    = 5'd17;
   localparam logic [4:0] TOK_LBRACE    = 5'd18;
   localparam logic [4:0] TOK_RBRACE    = 5'd19;
   localparam logic [4:0] TOK_LET       = 5'd20;
   localparam logic [4:0] TOK_FUNCTION  = 5'd21;
   localparam logic [4:0] TOK_TRUE      = 5'd22;
   localparam logic [4:0] TOK_FALSE     = 5'd23;
   localparam logic [4:0] TOK_IF        = 5'd24;
   localparam logic [4:0] TOK_ELSE      = 5'd25;
   localparam logic [4:0] TOK_RETURN    = 5'd26;

   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_ASSIGN = 8'h3d;

   // Number of leading bytes kept for keyword matching.
   localparam int KW_SLOTS = 6;
   localparam int KW_COUNT = 7;

   // Keywords, first byte in the lowest bits, zero padded.
   localparam logic [8*KW_SLOTS-1:0] KW_TEXT [KW_COUNT] = '{
      48'h0000_0074_656c,   // let
      48'h0000_0000_6e66,   // fn
      48'h0000_6575_7274,   // true
      48'h0065_736c_6166,   // false
      48'h0000_0000_6669,   // if
      48'h0000_6573_6c65,   // else
      48'h6e72_7574_6572    // return
   };

   typedef struct packed {
      logic [4:0] kind;
      logic [15:0] start;
      logic [7:0] len;
      logic [7:0] ch;
      logic last;
   } tok_type;

   // Up to two tokens produced by one input beat, in delivery order.
   typedef struct packed {
      logic valid0;
      logic valid1;
      tok_type tok0;
      tok_type tok1;
   } push_type;

   // Kind of an identifier given its leading bytes; the run must be short enough.
   function automatic logic [4:0] kw_kind(input logic [8*KW_SLOTS-1:0] chars);
      logic [4:0] kind;
      kind = TOK_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (chars == KW_TEXT[k]) begin
            kind = TOK_LET + 5'(k);
         end
      end
      return kind;
   endfunction

   // Kind of a byte that is a token on its own.
   function automatic logic [4:0] single_kind(input logic [7:0] b);
      logic [4:0] kind;
      case (b)
         8'h2b:   kind = TOK_PLUS;
         8'h2d:   kind = TOK_MINUS;
         8'h2a:   kind = TOK_ASTERISK;
         8'h2f:   kind = TOK_SLASH;
         8'h3c:   kind = TOK_LT;
         8'h3e:   kind = TOK_GT;
         8'h2c:   kind = TOK_COMMA;
         8'h3b:   kind = TOK_SEMICOLON;
         8'h28:   kind = TOK_LPAREN;
         8'h29:   kind = TOK_RPAREN;
         8'h7b:   kind = TOK_LBRACE;
         8'h7d:   kind = TOK_RBRACE;
         default: kind = TOK_ILLEGAL;
      endcase
      return kind;
   endfunction

endpackage

>>> hw/rtl/stsu_lexer.sv
// Scanner state and the per-byte token decision.
module stsu_lexer
   import stsu_pkg::*;
#(
   parameter int POS_BITS = 16,
   parameter int MAX_TOKEN_LEN = 255
) (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic end_item,
   input  logic [7:0] src_byte,
   output push_type push
);

   localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);
   localparam int LEN_W = (LEN_BITS > 8) ? LEN_BITS : 8;
   localparam int POS_W = (POS_BITS > 16) ? POS_BITS : 16;

   logic [2:0] cls_ff, cls_in;
   logic [POS_BITS-1:0] start_ff, start_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [8*KW_SLOTS-1:0] kw_ff, kw_in;
   logic kwok_ff, kwok_in;

   logic is_end, letter, digit, space;
   logic [LEN_W-1:0] len_ext;
   logic [POS_W-1:0] start_ext, pos_ext;
   tok_type flush_tok, new_tok;
   logic flush_v, new_v;

   always_comb begin
      is_end = end_item || (src_byte == 8'h00);
      letter = (src_byte inside {[8'h61:8'h7a], [8'h41:8'h5a], 8'h5f});
      digit  = (src_byte inside {[8'h30:8'h39]});
      space  = (src_byte inside {8'h20, 8'h09, 8'h0a, 8'h0d});
      len_ext   = LEN_W'(len_ff);
      start_ext = POS_W'(start_ff);
      pos_ext   = POS_W'(pos_ff);
   end

   // The token that the pending run turns into when it is closed.
   always_comb begin
      flush_tok = '0;
      flush_tok.start = start_ext[15:0];
      flush_tok.len = len_ext[7:0];
      flush_tok.ch = kw_ff[7:0];
      case (cls_ff)
         CLS_IDENT:  flush_tok.kind = kwok_ff ? kw_kind(kw_ff) : TOK_IDENT;
         CLS_NUMBER: flush_tok.kind = TOK_INT;
         CLS_BANG: begin
            flush_tok.kind = TOK_BANG;
            flush_tok.len = 8'd1;
            flush_tok.ch = CH_BANG;
         end
         CLS_ASSIGN: begin
            flush_tok.kind = TOK_ASSIGN;
            flush_tok.len = 8'd1;
            flush_tok.ch = CH_ASSIGN;
         end
         default: flush_tok.kind = TOK_ILLEGAL;
      endcase
   end

   always_comb begin
      cls_in = cls_ff;
      start_in = start_ff;
      len_in = len_ff;
      pos_in = pos_ff;
      kw_in = kw_ff;
      kwok_in = kwok_ff;
      flush_v = 1'b0;
      new_v = 1'b0;
      new_tok = '0;
      new_tok.start = pos_ext[15:0];

      if (is_end) begin
         flush_v = (cls_ff != CLS_NONE);
         new_v = 1'b1;
         new_tok.kind = TOK_EOF;
         cls_in = CLS_NONE;
         start_in = '0;
         len_in = '0;
         pos_in = '0;
         kw_in = '0;
         kwok_in = 1'b1;
      end else begin
         pos_in = pos_ff + 1'b1;
         if ((cls_ff == CLS_IDENT && letter) || (cls_ff == CLS_NUMBER && digit)) begin
            for (int i = 0; i < KW_SLOTS; i++) begin
               if (len_ff == LEN_BITS'(i)) begin
                  kw_in[8*i +: 8] = src_byte;
               end
            end
            if (len_ff >= LEN_BITS'(KW_SLOTS)) begin
               kwok_in = 1'b0;
            end
            if (len_ff != LEN_BITS'(MAX_TOKEN_LEN)) begin
               len_in = len_ff + 1'b1;
            end
         end else if ((cls_ff == CLS_BANG || cls_ff == CLS_ASSIGN) && src_byte == CH_ASSIGN) begin
            new_v = 1'b1;
            new_tok.kind = (cls_ff == CLS_BANG) ? TOK_NOT_EQ : TOK_EQ;
            new_tok.start = start_ext[15:0];
            new_tok.len = 8'd2;
            new_tok.ch = (cls_ff == CLS_BANG) ? CH_BANG : CH_ASSIGN;
            cls_in = CLS_NONE;
         end else begin
            flush_v = (cls_ff != CLS_NONE);
            cls_in = CLS_NONE;
            if (!space) begin
               if (letter || digit || src_byte == CH_BANG || src_byte == CH_ASSIGN) begin
                  if (letter) begin
                     cls_in = CLS_IDENT;
                  end else if (digit) begin
                     cls_in = CLS_NUMBER;
                  end else if (src_byte == CH_BANG) begin
                     cls_in = CLS_BANG;
                  end else begin
                     cls_in = CLS_ASSIGN;
                  end
                  start_in = pos_ff;
                  len_in = LEN_BITS'(1);
                  kw_in = {{(8*KW_SLOTS-8){1'b0}}, src_byte};
                  kwok_in = 1'b1;
               end else begin
                  new_v = 1'b1;
                  new_tok.kind = single_kind(src_byte);
                  new_tok.len = 8'd1;
                  new_tok.ch = src_byte;
               end
            end
         end
      end

      // Order the tokens: a flushed run always goes out before the new token.
      push.valid0 = step && (flush_v || new_v);
      push.valid1 = step && flush_v && new_v;
      push.tok0 = flush_v ? flush_tok : new_tok;
      push.tok0.last = !(flush_v && new_v);
      push.tok1 = new_tok;
      push.tok1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff <= CLS_NONE;
         start_ff <= '0;
         len_ff <= '0;
         pos_ff <= '0;
         kw_ff <= '0;
         kwok_ff <= 1'b1;
      end else if (step) begin
         cls_ff <= cls_in;
         start_ff <= start_in;
         len_ff <= len_in;
         pos_ff <= pos_in;
         kw_ff <= kw_in;
         kwok_ff <= kwok_in;
      end
   end

endmodule

>>> hw/rtl/stsu_rsp_fifo.sv
// Four-entry token queue that takes up to two tokens a cycle and hands out one.
module stsu_rsp_fifo
   import stsu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  push_type push,
   output logic room,
   output logic out_valid,
   input  logic out_ready,
   output tok_type out_tok
);

   tok_type entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic pop;

   always_comb begin
      room = (count_ff <= 3'd2);
      out_valid = (count_ff != 3'd0);
      out_tok = entry_ff[rd_ptr_ff];
      pop = out_valid && out_ready;
      wr_ptr_in = wr_ptr_ff + {1'b0, push.valid0} + {1'b0, push.valid1};
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in = count_ff + {2'b00, push.valid0} + {2'b00, push.valid1} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         entry_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.valid1) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> hw/rtl/source_token_scanner_unit.sv
// Top level of the source token scanner: input register, lexer and token queue.
//
// The scanner takes one source byte per beat on the req_ stream and emits tokens
// on the rsp_ stream. A beat whose tuser bit is set, or whose byte is zero, ends
// the input: any pending token is flushed, an EOF token follows, and the scanner
// returns to its reset state with the position back at zero. Each token carries
// its kind, the position of its first byte, its length in bytes and its first
// byte; tlast marks the last token caused by one input beat. Identifiers, numbers
// and a lone '!' or '=' are held until the next byte shows where they end, so a
// token usually appears one beat after its last byte. A new byte is accepted
// every cycle as long as the token queue has room for two more tokens. Each
// input beat makes at most two tokens and the output hands out one token per
// cycle, so the sustained rate is one byte per cycle when the stream makes at
// most one token per byte on average and the consumer keeps tready high; a beat
// that makes two tokens needs an output turn for each. An accepted byte passes
// through the input register and then the token queue before its token shows
// on rsp_tdata.
module source_token_scanner_unit
   import stsu_pkg::*;
#(
   parameter int POS_BITS = 16,
   parameter int MAX_TOKEN_LEN = 255
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // [7:0] src_byte
   input  logic [0:0] req_tuser,   // [0] req_type (1 = end of input)
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [39:0] rsp_tdata,  // [4:0] token_kind, [20:5] start_pos,
                                   // [28:21] token_len, [36:29] char_code, zero above
   output logic rsp_tlast          // last_of_run
);

   logic in_valid_ff, in_valid_in;
   logic in_end_ff;
   logic [7:0] in_byte_ff;
   logic room, step;
   push_type push;
   tok_type out_tok;

   // The held byte is scanned once the queue can absorb the two tokens it may make.
   always_comb begin
      step = in_valid_ff && room;
      req_tready = !in_valid_ff || step;
      in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !step);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_end_ff <= req_tuser[0];
         in_byte_ff <= req_tdata;
      end
   end

   stsu_lexer #(
      .POS_BITS(POS_BITS),
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
   ) u_lexer (
      .clock(clock),
      .reset(reset),
      .step(step),
      .end_item(in_end_ff),
      .src_byte(in_byte_ff),
      .push(push)
   );

   stsu_rsp_fifo u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .room(room),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_tok(out_tok)
   );

   assign rsp_tdata = {3'b000, out_tok.ch, out_tok.len, out_tok.start, out_tok.kind};
   assign rsp_tlast = out_tok.last;

endmodule

>>> verif/tb_source_token_scanner_unit.sv
// Self-checking testbench for the source token scanner: stream drivers, token predictor, checks.
module tb_source_token_scanner_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import stsu_pkg::*;

   // Run shape. The idle limit is far above the longest correct pause: the deliberate
   // hold-off on the token side plus the longest gap the source side takes.
   localparam int IDLE_LIMIT      = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AFTER  = 120;
   localparam int RANDOM_BEATS    = 550;
   localparam int DRAIN_CYCLES    = 20;
   localparam int MAX_LEN         = 255;

   localparam logic [7:0] BLANKS [4] = '{8'h20, 8'h09, 8'h0a, 8'h0d};
   localparam string NAME_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   localparam string DIGIT_CHARS = "0123456789";
   localparam string SOUP_CHARS = "+-*/<>,;(){}!=";
   localparam string MATH_CHARS = "+-*/<>";

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [7:0]  len;
      logic [7:0]  ch;
      logic        last;
   } token_t;

   typedef struct packed {
      logic       fin;
      logic [7:0] ch;
   } beat_t;

   typedef enum int {RX_STEADY, RX_RANDOM, RX_THIRD, RX_BURSTY} rx_pattern_t;

   // Token predictor and checker. It keeps its own copy of the scanner state, works out
   // the tokens each accepted source beat must produce, and matches arriving tokens
   // against the oldest of them.
   class token_scoreboard;
      token_t      pending_tokens[$];
      token_t      beat_tokens[$];
      int          failures;
      int          checked;
      int          eof_count;
      logic [26:0] kinds_seen;

      logic [2:0]  run_class;
      logic [15:0] run_start;
      logic [7:0]  run_length;
      logic [15:0] next_pos;
      logic [47:0] lead_bytes;
      bit          keyword_ok;
      string       keywords[7];

      function new();
         keywords = '{"let", "fn", "true", "false", "if", "else", "return"};
         failures = 0;
         checked = 0;
         eof_count = 0;
         kinds_seen = '0;
         clear_state();
      endfunction

      function void clear_state();
         run_class = CLS_NONE;
         run_start = '0;
         run_length = '0;
         next_pos = '0;
         lead_bytes = '0;
         keyword_ok = 1'b1;
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= 10) begin
            $display("ERROR: %s", msg);
         end
      endfunction

      function string show(token_t t);
         return $sformatf("kind %0d start %0d len %0d char %02h last %0b",
                          t.kind, t.start, t.len, t.ch, t.last);
      endfunction

      function void add_token(logic [4:0] kind, logic [15:0] start, logic [7:0] len,
                              logic [7:0] ch);
         token_t t;
         t.kind = kind;
         t.start = start;
         t.len = len;
         t.ch = ch;
         t.last = 1'b0;
         beat_tokens.push_back(t);
      endfunction

      // An identifier can only be a keyword while all of its bytes were kept.
      function logic [4:0] word_kind();
         bit hit;
         if (!keyword_ok || run_length > KW_SLOTS) return TOK_IDENT;
         for (int k = 0; k < 7; k++) begin
            if (keywords[k].len() == run_length) begin
               hit = 1'b1;
               for (int i = 0; i < keywords[k].len(); i++) begin
                  if (lead_bytes[8*i +: 8] != 8'(keywords[k][i])) hit = 1'b0;
               end
               if (hit) return TOK_LET + 5'(k);
            end
         end
         return TOK_IDENT;
      endfunction

      function logic [4:0] lone_kind(logic [7:0] ch);
         case (ch)
            "+":     return TOK_PLUS;
            "-":     return TOK_MINUS;
            "*":     return TOK_ASTERISK;
            "/":     return TOK_SLASH;
            "<":     return TOK_LT;
            ">":     return TOK_GT;
            ",":     return TOK_COMMA;
            ";":     return TOK_SEMICOLON;
            "(":     return TOK_LPAREN;
            ")":     return TOK_RPAREN;
            "{":     return TOK_LBRACE;
            "}":     return TOK_RBRACE;
            default: return TOK_ILLEGAL;
         endcase
      endfunction

      function void flush_run();
         case (run_class)
            CLS_IDENT:  add_token(word_kind(), run_start, run_length, lead_bytes[7:0]);
            CLS_NUMBER: add_token(TOK_INT, run_start, run_length, lead_bytes[7:0]);
            CLS_BANG:   add_token(TOK_BANG, run_start, 8'd1, CH_BANG);
            CLS_ASSIGN: add_token(TOK_ASSIGN, run_start, 8'd1, CH_ASSIGN);
            default: ;
         endcase
         run_class = CLS_NONE;
      endfunction

      function void open_run(logic [2:0] cls, logic [15:0] here, logic [7:0] ch);
         run_class = cls;
         run_start = here;
         run_length = 8'd1;
         lead_bytes = {40'h0, ch};
         keyword_ok = 1'b1;
      endfunction

      // Bytes past the sixth rule out a keyword; the length stops at its maximum.
      function void grow_run(logic [7:0] ch);
         if (run_length < KW_SLOTS) lead_bytes[8*run_length +: 8] = ch;
         else keyword_ok = 1'b0;
         if (run_length < MAX_LEN) run_length++;
      endfunction

      function void note_beat(logic fin, logic [7:0] ch);
         logic [15:0] here;
         bit letter;
         bit digit;
         bit blank;
         letter = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
         digit = ch >= "0" && ch <= "9";
         blank = ch == BLANKS[0] || ch == BLANKS[1] || ch == BLANKS[2] || ch == BLANKS[3];
         here = next_pos;
         beat_tokens.delete();
         if (fin || ch == 8'h00) begin
            // End of input: flush, EOF at the current position, back to reset state.
            flush_run();
            add_token(TOK_EOF, here, 8'd0, 8'h00);
            clear_state();
            eof_count++;
         end else begin
            next_pos = here + 16'd1;
            if (run_class == CLS_IDENT && letter) begin
               grow_run(ch);
            end else if (run_class == CLS_NUMBER && digit) begin
               grow_run(ch);
            end else if ((run_class == CLS_BANG || run_class == CLS_ASSIGN) &&
                         ch == CH_ASSIGN) begin
               if (run_class == CLS_BANG) add_token(TOK_NOT_EQ, run_start, 8'd2, CH_BANG);
               else add_token(TOK_EQ, run_start, 8'd2, CH_ASSIGN);
               run_class = CLS_NONE;
            end else begin
               flush_run();
               if (blank) begin
               end else if (letter) begin
                  open_run(CLS_IDENT, here, ch);
               end else if (digit) begin
                  open_run(CLS_NUMBER, here, ch);
               end else if (ch == CH_BANG) begin
                  open_run(CLS_BANG, here, ch);
               end else if (ch == CH_ASSIGN) begin
                  open_run(CLS_ASSIGN, here, ch);
               end else begin
                  add_token(lone_kind(ch), here, 8'd1, ch);
               end
            end
         end
         if (beat_tokens.size() > 0) beat_tokens[beat_tokens.size()-1].last = 1'b1;
         foreach (beat_tokens[i]) pending_tokens.push_back(beat_tokens[i]);
      endfunction

      function void check_token(logic [39:0] data, logic last);
         token_t got;
         token_t want;
         got.kind = data[4:0];
         got.start = data[20:5];
         got.len = data[28:21];
         got.ch = data[36:29];
         got.last = last;
         if (pending_tokens.size() == 0) begin
            report({"token with none expected: ", show(got)});
            return;
         end
         want = pending_tokens.pop_front();
         checked++;
         if (got.kind <= 5'd26) kinds_seen[got.kind] = 1'b1;
         if (got.kind !== want.kind || got.start !== want.start || got.len !== want.len ||
             got.ch !== want.ch || got.last !== want.last) begin
            report($sformatf("token %0d: expected %s, got %s", checked, show(want),
                             show(got)));
         end
      endfunction

      function void check_drained();
         if (pending_tokens.size() > 0) begin
            report($sformatf("%0d expected tokens never arrived, oldest %s",
                             pending_tokens.size(), show(pending_tokens[0])));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   token_scoreboard sb;
   beat_t           source_q[$];
   int              stim_beats;
   int              beats_taken;

   source_token_scanner_unit i_dut (
      .clock,
      .reset,
      .req_tvalid,
      .req_tready,
      .req_tdata,
      .req_tuser,
      .rsp_tvalid,
      .rsp_tready,
      .rsp_tdata,
      .rsp_tlast
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Stimulus is built ahead of the run as a queue of source beats.
   function automatic void put_beat(logic fin, logic [7:0] ch);
      source_q.push_back('{fin, ch});
      stim_beats++;
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_beat(1'b0, s[i]);
   endfunction

   // Input ends either with an end beat carrying a junk byte or with a zero byte.
   function automatic void put_end();
      if ($urandom_range(0, 1)) put_beat(1'b1, 8'($urandom_range(0, 255)));
      else put_beat(1'b0, 8'h00);
   endfunction

   function automatic string pick_run(string pool, int count);
      string word;
      int k;
      word = "";
      repeat (count) begin
         k = $urandom_range(0, pool.len() - 1);
         word = {word, pool.substr(k, k)};
      end
      return word;
   endfunction

   function automatic string pick_space();
      string blank;
      blank = " ";
      blank[0] = BLANKS[$urandom_range(0, 3)];
      case ($urandom_range(0, 5))
         0:       return "";
         1:       return "  ";
         default: return blank;
      endcase
   endfunction

   // Mostly keywords and near misses of them, so the keyword match is pushed hard.
   function automatic string pick_name();
      string kw[7] = '{"let", "fn", "true", "false", "if", "else", "return"};
      string word;
      int sel;
      sel = $urandom_range(0, 9);
      word = kw[$urandom_range(0, 6)];
      if (sel >= 6) begin
         word = pick_run(NAME_CHARS, $urandom_range(1, 8));
      end else if (sel >= 4) begin
         case ($urandom_range(0, 2))
            0:       word = {word, pick_run(NAME_CHARS, 1)};
            1:       word = word.substr(0, word.len() - 2);
            default: word = {word.substr(0, 0).toupper(), word.substr(1, word.len() - 1)};
         endcase
      end
      return word;
   endfunction

   function automatic string pick_operand();
      case ($urandom_range(0, 3))
         0, 1:    return pick_name();
         2:       return pick_run(DIGIT_CHARS, $urandom_range(1, 4));
         default: return {"!", pick_name()};
      endcase
   endfunction

   function automatic string pick_expr();
      return {pick_operand(), pick_space(), pick_run(MATH_CHARS, 1), pick_space(),
              pick_operand()};
   endfunction

   // Every accepted beat on either side is seen here, the source side first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_beat(req_tuser[0], req_tdata);
            beats_taken++;
         end
         if (rsp_tvalid && rsp_tready) sb.check_token(rsp_tdata, rsp_tlast);
      end
   end

   // Source side: bursts of random length with random gaps, including long bursts
   // with no gap at all. An offered beat stays up until it is taken.
   initial begin : drive_source
      int burst_left;
      int gap_left;
      req_tvalid <= 1'b0;
      req_tdata <= 8'h00;
      req_tuser <= 1'b0;
      burst_left = 1;
      gap_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      while (source_q.size() > 0) begin
         @(posedge clock);
         if (req_tvalid && req_tready) void'(source_q.pop_front());
         else if (req_tvalid) continue;
         if (source_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tuser <= source_q[0].fin;
            req_tdata <= source_q[0].ch;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                        : $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Token side: switches among steady, random, one-in-three and bursty stall
   // patterns. Once, early in the run, it holds off for a long stretch while the
   // source keeps offering, so the token queue fills and the scanner stalls its input.
   initial begin : drain_tokens
      rx_pattern_t pattern;
      int pattern_left;
      int stall_left;
      int hold_left;
      int phase;
      bit held_off;
      pattern = RX_STEADY;
      pattern_left = 0;
      stall_left = 0;
      hold_left = 0;
      phase = 0;
      held_off = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!held_off && beats_taken >= HOLD_OFF_AFTER) begin
            held_off = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern = rx_pattern_t'($urandom_range(0, 3));
               pattern_left = $urandom_range(40, 160);
            end
            pattern_left--;
            phase++;
            case (pattern)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_RANDOM: rsp_tready <= ($urandom_range(0, 99) >= 35);
               RX_THIRD:  rsp_tready <= (phase % 3 == 0);
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     rsp_tready <= 1'b0;
                  end else if ($urandom_range(0, 9) == 0) begin
                     stall_left = $urandom_range(1, 12);
                     rsp_tready <= 1'b0;
                  end else begin
                     rsp_tready <= 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // Ends the run when no beat moves on either side for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Timeout: nothing moved for %0d cycles, %0d source beats taken, %0d left",
               IDLE_LIMIT, beats_taken, source_q.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : run_test
      int seg;
      int saved;
      int total_beats;
      string cmp;
      reset <= 1'b1;
      sb = new();
      beats_taken = 0;
      stim_beats = 0;

      // Directed opening. A zero byte with nothing gathered gives a lone EOF at zero.
      put_beat(1'b0, 8'h00);
      put_text("9z_");            // a letter closes a number and starts a name
      put_text("!=");
      put_text("==");
      put_text("!");              // a lone bang flushed by a high byte,
      put_beat(1'b0, 8'hff);      // which is illegal like every byte from 128 up
      put_text("=");
      put_beat(1'b0, 8'h80);
      put_text("Az9");            // a digit closes a name
      put_beat(1'b1, 8'hff);      // end beat: its byte is ignored, the number is flushed
      put_text("if");
      put_beat(1'b0, 8'h00);

      // Random part: mostly well-formed statements with random content, then token
      // soup, raw noise bytes, ends of input and long runs. It opens with a name long
      // enough to saturate the length, whose first six bytes spell a keyword.
      stim_beats = 0;
      put_text({"return", pick_run(NAME_CHARS, 254), " "});
      while (stim_beats < RANDOM_BEATS) begin
         seg = $urandom_range(0, 99);
         if (seg < 45) begin
            case ($urandom_range(0, 3))
               0: put_text({"let ", pick_name(), pick_space(), "=", pick_space(),
                            pick_expr(), ";"});
               1: put_text({"fn(", pick_name(), ",", pick_space(), pick_name(), ")",
                            pick_space(), "{", pick_space(), "return ", pick_expr(),
                            ";", pick_space(), "}"});
               2: put_text({"if", pick_space(), "(", pick_expr(), ")", "{", pick_name(),
                            "}", pick_space(), "else", pick_space(), "{", pick_name(),
                            "}"});
               default: begin
                  if ($urandom_range(0, 1)) cmp = "!=";
                  else cmp = "==";
                  put_text({pick_expr(), pick_space(), cmp, pick_space(),
                            pick_expr(), ";"});
               end
            endcase
         end else if (seg < 70) begin
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 3))
                  0:       put_text(pick_name());
                  1:       put_text(pick_run(DIGIT_CHARS, $urandom_range(1, 5)));
                  default: put_text(pick_run(SOUP_CHARS, $urandom_range(1, 3)));
               endcase
               put_text(pick_space());
            end
         end else if (seg < 80) begin
            repeat ($urandom_range(1, 6)) put_beat(1'b0, 8'($urandom_range(1, 255)));
         end else if (seg < 90) begin
            put_end();
         end else begin
            // Runs past the keyword window, now and then past the length limit.
            saved = ($urandom_range(0, 4) == 0) ? $urandom_range(250, 270)
                                                : $urandom_range(7, 20);
            if ($urandom_range(0, 1)) put_text(pick_run(NAME_CHARS, saved));
            else put_text(pick_run(DIGIT_CHARS, saved));
         end
         put_text(pick_space());
      end
      put_end();
      total_beats = source_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (beats_taken < total_beats || sb.pending_tokens.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.check_drained();

      $display("Scanned %0d source beats in %0d inputs, under bursty input and output stalls.",
               beats_taken, sb.eof_count);
      $display("Checked %0d tokens covering %0d of 27 token kinds, %0d failures.",
               sb.checked, $countones(sb.kinds_seen), sb.failures);
      if (sb.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
